>>> sv/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding window min / mean / max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
	localparam int SAMPLE_W   = 16;
	localparam int NUM_W      = 16;
	localparam int MEAN_W     = 24;
	localparam int SUM_W      = SAMPLE_W + ADDR_W;
	localparam int DIVD_W     = SUM_W + 8;
	localparam int DCNT_W     = $clog2(DIVD_W);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [LEN_W-1:0] WL_RESET   = LEN_W'(3);
	localparam logic [LEN_W-1:0] WL_MAX     = LEN_W'(MAX_WINDOW);
	localparam logic [NUM_W-1:0] NUM_WRAP   = {NUM_W{1'b1}};

	// Work descriptor handed from front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] pad;
		logic [NUM_W-1:0]           num;
		logic [ADDR_W-1:0]          pos;
		logic [LEN_W-1:0]           fill;
		logic [LEN_W-1:0]           len;
	} desc_t;

	typedef struct packed {
		logic [NUM_W-1:0]           num;
		logic signed [SAMPLE_W-1:0] value;
		logic signed [SAMPLE_W-1:0] min;
		logic signed [MEAN_W-1:0]   mean;
		logic signed [SAMPLE_W-1:0] max;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

>>> sv/swmm_ram.sv
// ----------------------------------------------------------------------------
// swmm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/swmm_front.sv
// ----------------------------------------------------------------------------
// swmm_front
// Input side: sample numbering, set tracking, write position, window length.
// ----------------------------------------------------------------------------
module swmm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [swmm_pkg::LEN_W-1:0]     cfg_wdata,
	input  logic                           push,
	input  logic                           q_full,
	input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
	input  logic                           last,
	output logic                           q_push,
	output swmm_pkg::desc_t                q_data
);

	logic [swmm_pkg::LEN_W-1:0]           wl_q;
	logic [swmm_pkg::LEN_W-1:0]           len;
	logic                                 set_start_q;
	logic [swmm_pkg::NUM_W-1:0]           num_q;
	logic [swmm_pkg::NUM_W-1:0]           num_nxt;
	logic [swmm_pkg::ADDR_W-1:0]          wp_q;
	logic [swmm_pkg::LEN_W-1:0]           fill_q;
	logic [swmm_pkg::LEN_W-1:0]           fill_nxt;
	logic signed [swmm_pkg::SAMPLE_W-1:0] pad_q;
	logic signed [swmm_pkg::SAMPLE_W-1:0] pad_nxt;

	assign q_push = push && !q_full;

	always_comb begin
		if (wl_q == '0) begin
			len = swmm_pkg::LEN_W'(1);
		end else if (wl_q > swmm_pkg::WL_MAX) begin
			len = swmm_pkg::WL_MAX;
		end else begin
			len = wl_q;
		end
	end

	always_comb begin
		if (set_start_q) begin
			num_nxt  = swmm_pkg::NUM_W'(1);
			fill_nxt = swmm_pkg::LEN_W'(1);
			pad_nxt  = sample;
		end else begin
			num_nxt  = (num_q == swmm_pkg::NUM_WRAP) ? swmm_pkg::NUM_W'(1)
				: num_q + swmm_pkg::NUM_W'(1);
			fill_nxt = (fill_q == swmm_pkg::WL_MAX) ? fill_q
				: fill_q + swmm_pkg::LEN_W'(1);
			pad_nxt  = pad_q;
		end
	end

	always_comb begin
		q_data.sample = sample;
		q_data.pad    = pad_nxt;
		q_data.num    = num_nxt;
		q_data.pos    = wp_q;
		q_data.fill   = fill_nxt;
		q_data.len    = len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q        <= swmm_pkg::WL_RESET;
			set_start_q <= 1'b1;
			num_q       <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
		end else begin
			if (cfg_we) begin
				wl_q <= cfg_wdata;
			end
			if (q_push) begin
				set_start_q <= last;
				num_q       <= num_nxt;
				wp_q        <= wp_q + swmm_pkg::ADDR_W'(1);
				fill_q      <= fill_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			pad_q <= pad_nxt;
		end
	end

endmodule

>>> sv/swmm_queue.sv
// ----------------------------------------------------------------------------
// swmm_queue
// Short descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
module swmm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  swmm_pkg::desc_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output swmm_pkg::desc_t rd_data,
	output logic            q_empty
);

	swmm_pkg::desc_t                entry_q [swmm_pkg::QDEPTH];
	logic [swmm_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [swmm_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [swmm_pkg::QCNT_W-1:0]    cnt_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full    = (cnt_q == swmm_pkg::QCNT_W'(swmm_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + swmm_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + swmm_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + swmm_pkg::QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - swmm_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= swmm_pkg::QCNT_W'(swmm_pkg::QDEPTH))
		else $error("queue count above depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == swmm_pkg::QCNT_W'(swmm_pkg::QDEPTH))
		|-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");
	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> cnt_q == $past(cnt_q) + swmm_pkg::QCNT_W'(1))
		else $error("queue write not counted");
`endif

endmodule

>>> sv/swmm_back.sv
// ----------------------------------------------------------------------------
// swmm_back
// Execution side: store write, window scan for min/max/sum, serial divide,
// result register.
// ----------------------------------------------------------------------------
module swmm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  swmm_pkg::desc_t                   q_data,
	output logic                              q_pop,
	output logic                              ram_we,
	output logic [swmm_pkg::ADDR_W-1:0]       ram_waddr,
	output logic [swmm_pkg::SAMPLE_W-1:0]     ram_wdata,
	output logic [swmm_pkg::ADDR_W-1:0]       ram_raddr,
	input  logic [swmm_pkg::SAMPLE_W-1:0]     ram_rdata,
	input  logic                              pop,
	output logic                              empty,
	output swmm_pkg::res_t                    res
);

	swmm_pkg::state_t                     state_q;
	swmm_pkg::state_t                     state_nxt;
	swmm_pkg::desc_t                      desc_q;
	logic [swmm_pkg::LEN_W-1:0]           k_q;
	logic                                 rd_s1;
	logic                                 pad_s1;
	logic signed [swmm_pkg::SAMPLE_W-1:0] v;
	logic signed [swmm_pkg::SAMPLE_W-1:0] lo_q;
	logic signed [swmm_pkg::SAMPLE_W-1:0] hi_q;
	logic signed [swmm_pkg::SUM_W-1:0]    sum_q;
	logic signed [swmm_pkg::SUM_W-1:0]    sum_abs;
	logic                                 neg_q;
	logic [swmm_pkg::DIVD_W-1:0]          dvd_q;
	logic [swmm_pkg::LEN_W-1:0]           rem_q;
	logic [swmm_pkg::LEN_W:0]             trial;
	logic                                 ge;
	logic [swmm_pkg::DCNT_W-1:0]          dcnt_q;
	logic [swmm_pkg::DIVD_W-1:0]          quo_signed;
	logic                                 scan_issue;
	logic                                 scan_end;
	logic                                 load;
	logic                                 out_valid_q;
	swmm_pkg::res_t                       res_q;

	assign scan_end = (k_q == desc_q.len - swmm_pkg::LEN_W'(1));
	assign load     = (state_q == swmm_pkg::ST_DONE) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign res      = res_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			swmm_pkg::ST_IDLE: begin
				if (!q_empty) state_nxt = swmm_pkg::ST_SCAN;
			end
			swmm_pkg::ST_SCAN: begin
				if (scan_end) state_nxt = swmm_pkg::ST_DRAIN;
			end
			swmm_pkg::ST_DRAIN: state_nxt = swmm_pkg::ST_PREP;
			swmm_pkg::ST_PREP:  state_nxt = swmm_pkg::ST_DIV;
			swmm_pkg::ST_DIV: begin
				if (dcnt_q == '0) state_nxt = swmm_pkg::ST_DONE;
			end
			swmm_pkg::ST_DONE: begin
				if (load) state_nxt = swmm_pkg::ST_IDLE;
			end
			default: state_nxt = swmm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		scan_issue = 1'b0;
		unique case (state_q)
			swmm_pkg::ST_IDLE: q_pop      = !q_empty;
			swmm_pkg::ST_SCAN: scan_issue = 1'b1;
			default: begin
				q_pop      = 1'b0;
				scan_issue = 1'b0;
			end
		endcase
	end

	assign ram_we    = q_pop;
	assign ram_waddr = q_data.pos;
	assign ram_wdata = q_data.sample;
	assign ram_raddr = desc_q.pos - k_q[swmm_pkg::ADDR_W-1:0];

	assign v       = pad_s1 ? desc_q.pad : $signed(ram_rdata);
	assign sum_abs = sum_q[swmm_pkg::SUM_W-1] ? -sum_q : sum_q;
	assign trial   = {rem_q, dvd_q[swmm_pkg::DIVD_W-1]};
	assign ge      = (trial >= {1'b0, desc_q.len});
	assign quo_signed = neg_q ? -dvd_q : dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swmm_pkg::ST_IDLE;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rd_s1   <= scan_issue;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_data;
			k_q    <= '0;
			lo_q   <= q_data.sample;
			hi_q   <= q_data.sample;
			sum_q  <= '0;
		end
		if (scan_issue) begin
			k_q    <= k_q + swmm_pkg::LEN_W'(1);
			pad_s1 <= (k_q >= desc_q.fill);
		end
		if (rd_s1) begin
			if (v < lo_q) lo_q <= v;
			if (v > hi_q) hi_q <= v;
			sum_q <= sum_q + swmm_pkg::SUM_W'(v);
		end
		if (state_q == swmm_pkg::ST_PREP) begin
			neg_q  <= sum_q[swmm_pkg::SUM_W-1];
			dvd_q  <= {sum_abs, 8'h00};
			rem_q  <= '0;
			dcnt_q <= swmm_pkg::DCNT_W'(swmm_pkg::DIVD_W - 1);
		end
		if (state_q == swmm_pkg::ST_DIV) begin
			rem_q  <= ge ? swmm_pkg::LEN_W'(trial - {1'b0, desc_q.len})
				: trial[swmm_pkg::LEN_W-1:0];
			dvd_q  <= {dvd_q[swmm_pkg::DIVD_W-2:0], ge};
			dcnt_q <= dcnt_q - swmm_pkg::DCNT_W'(1);
		end
		if (load) begin
			res_q.num   <= desc_q.num;
			res_q.value <= desc_q.sample;
			res_q.min   <= lo_q;
			res_q.mean  <= quo_signed[swmm_pkg::MEAN_W-1:0];
			res_q.max   <= hi_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swmm_pkg::ST_SCAN |-> k_q < desc_q.len)
		else $error("scan index past window");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == swmm_pkg::ST_IDLE)
		else $error("descriptor taken while busy");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swmm_pkg::ST_DIV && dcnt_q == '0 |=> state_q == swmm_pkg::ST_DONE)
		else $error("divide did not finish");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(res_q))
		else $error("waiting result overwritten");
`endif

endmodule

>>> sv/sliding_window_min_avg_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_avg_max
// Sliding window minimum, Q.8 mean and maximum over signed 16-bit samples.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result: its 1-based number in the set, the
// sample, and the min, mean*256 (truncated toward zero) and max over the last
// window_length samples (0 acts as 1, above 64 acts as 64). The first sample
// of a set pads the window with its own value; "last" ends the set. The front
// part takes an item whenever the queue is not full and queues up to two.
// The back part works on one item at a time: one store write, one store read
// per window entry through the single read port, a pipeline drain and a setup
// step, a serial divide of one quotient bit per cycle, and one hand-off to the
// output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sliding_window_min_avg_max (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [swmm_pkg::LEN_W-1:0]            cfg_wdata,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [swmm_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  last,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [swmm_pkg::NUM_W-1:0]            sample_number,
	output logic signed [swmm_pkg::SAMPLE_W-1:0]  value,
	output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_min,
	output logic signed [swmm_pkg::MEAN_W-1:0]    window_mean,
	output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_max
);

	logic                              q_push;
	swmm_pkg::desc_t                   q_wdata;
	swmm_pkg::desc_t                   q_rdata;
	logic                              q_empty;
	logic                              q_pop;
	logic                              ram_we;
	logic [swmm_pkg::ADDR_W-1:0]       ram_waddr;
	logic [swmm_pkg::SAMPLE_W-1:0]     ram_wdata;
	logic [swmm_pkg::ADDR_W-1:0]       ram_raddr;
	logic [swmm_pkg::SAMPLE_W-1:0]     ram_rdata;
	swmm_pkg::res_t                    res;

	swmm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.q_full    (full),
		.sample    (sample),
		.last      (last),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	swmm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.q_empty (q_empty)
	);

	swmm_ram #(
		.WIDTH (swmm_pkg::SAMPLE_W),
		.DEPTH (swmm_pkg::MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	swmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign sample_number = res.num;
	assign value         = res.value;
	assign window_min    = res.min;
	assign window_mean   = res.mean;
	assign window_max    = res.max;

endmodule
